### rtl/lprm_pkg.sv
// ----------------------------------------------------------------------------
// lprm_pkg
// Shared types, codes and constants of the looping PCM resampler / mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package lprm_pkg;

  localparam int SMP_W      = 16;
  localparam int RATE_W     = 18;
  localparam int GAIN_W     = 11;
  localparam int IDX_W      = 32;
  localparam int THEME_W    = 16;
  localparam int PHASE_W    = RATE_W;
  localparam int PSUM_W     = RATE_W + 1;
  localparam int ADV_W      = 3;
  localparam int GAIN_FRAC  = 8;
  // cur*rate + (nxt-cur)*phase stays below 2^35 in magnitude
  localparam int NUM_W      = 2 * SMP_W + 4;
  // any interpolated magnitude at or above 2^25 saturates once a nonzero gain applies
  localparam int QCLAMP_W   = 25;
  localparam int EXT_W      = NUM_W - GAIN_FRAC;
  localparam int MIX_W      = EXT_W + 2;
  localparam int MUL_STEPS  = RATE_W;
  localparam int DIV_STEPS  = NUM_W;
  localparam int GAIN_STEPS = GAIN_W;
  localparam int CNT_W      = $clog2(NUM_W);
  localparam int PCNT_W     = $clog2(PSUM_W);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = RATE_W;

  localparam int INPUT_RATE = 44100;
  localparam int ADV_MAX    = 7;
  localparam int THEME_MAX  = 31;

  localparam logic [RATE_W-1:0] OUTPUT_RATE_RST = RATE_W'(48000);
  localparam logic [GAIN_W-1:0] GAIN_RST        = GAIN_W'(256);

  // one bit per theme that loops; themes 27 and up never loop
  localparam logic [31:0] LOOP_MASK = 32'h01F9_7BFF;

  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_RATE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 1'd1;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_FETCH = 2'd2,
    OP_TICK  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_MIX    = 2'd0,
    KIND_FETCH  = 2'd1,
    KIND_REFUSE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CT_IDLE,
    CT_CALC,
    CT_PUSH
  } ctl_state_t;

  typedef enum logic [2:0] {
    LN_IDLE,
    LN_MUL,
    LN_ABS,
    LN_DIV,
    LN_GAIN,
    LN_SAT
  } ln_state_t;

  typedef struct packed {
    opcode_t                   opcode;
    logic [THEME_W-1:0]        theme;
    logic [IDX_W-1:0]          frame_count;
    logic [IDX_W-1:0]          loop_start;
    logic signed [SMP_W-1:0]   src_left;
    logic signed [SMP_W-1:0]   src_right;
    logic signed [SMP_W-1:0]   dry_left;
    logic signed [SMP_W-1:0]   dry_right;
  } in_item_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [SMP_W-1:0]   out_left;
    logic signed [SMP_W-1:0]   out_right;
    logic [IDX_W-1:0]          fetch_index;
    logic                      is_playing;
    logic                      last;
  } out_item_t;

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] pos;
  } take_t;

  // Next source frame to request: wrap to the loop frame past the end, or fail.
  function automatic take_t take_index(input logic [IDX_W-1:0] pos,
                                       input logic [IDX_W-1:0] frames,
                                       input logic [IDX_W-1:0] loop_frame,
                                       input logic             loop_en);
    take_t            t;
    logic [IDX_W-1:0] p;
    p    = pos;
    t.ok = 1'b1;
    if (pos >= frames) begin
      if (!loop_en || loop_frame >= frames) begin
        t.ok = 1'b0;
      end else begin
        p = loop_frame;
      end
    end
    t.idx = p;
    t.pos = p + IDX_W'(1);
    return t;
  endfunction

endpackage

`default_nettype wire

### rtl/lprm_pdiv.sv
// ----------------------------------------------------------------------------
// lprm_pdiv
// Bit-serial restoring divider for the phase step: quotient gives the
// number of source frames to advance, remainder the new phase.
// ----------------------------------------------------------------------------
`default_nettype none

module lprm_pdiv (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [lprm_pkg::PSUM_W-1:0]   dividend,
  input  wire logic [lprm_pkg::RATE_W-1:0]   divisor,
  output logic                               busy,
  output logic [lprm_pkg::PSUM_W-1:0]        quot,
  output logic [lprm_pkg::RATE_W-1:0]        rem
);

  logic                          busy_r, busy_nxt;
  logic [lprm_pkg::PCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [lprm_pkg::PSUM_W-1:0]   dq_r, dq_nxt;
  logic [lprm_pkg::RATE_W-1:0]   rem_r, rem_nxt;
  logic [lprm_pkg::RATE_W-1:0]   dvs_r, dvs_nxt;
  logic [lprm_pkg::RATE_W:0]     trial, diff;
  logic                          ge;

  always_comb begin
    trial    = {rem_r, dq_r[lprm_pkg::PSUM_W-1]};
    diff     = trial - {1'b0, dvs_r};
    ge       = trial >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = lprm_pkg::PCNT_W'(lprm_pkg::PSUM_W - 1);
      dq_nxt   = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // shift in one quotient bit per cycle
      dq_nxt  = {dq_r[lprm_pkg::PSUM_W-2:0], ge};
      rem_nxt = ge ? diff[lprm_pkg::RATE_W-1:0] : trial[lprm_pkg::RATE_W-1:0];
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy = busy_r;
  assign quot = dq_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

### rtl/lprm_lane.sv
// ----------------------------------------------------------------------------
// lprm_lane
// One audio channel: bit-serial interpolation multiply, restoring divide by
// the output rate, bit-serial gain multiply and saturating mix.
// ----------------------------------------------------------------------------
`default_nettype none

module lprm_lane (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic signed [lprm_pkg::SMP_W-1:0]   cur,
  input  wire logic signed [lprm_pkg::SMP_W-1:0]   nxt,
  input  wire logic [lprm_pkg::PHASE_W-1:0]        phase,
  input  wire logic [lprm_pkg::RATE_W-1:0]         rate,
  input  wire logic [lprm_pkg::GAIN_W-1:0]         gain,
  input  wire logic signed [lprm_pkg::SMP_W-1:0]   dry,
  output logic                                     busy,
  output logic signed [lprm_pkg::SMP_W-1:0]        mix
);

  localparam int NW = lprm_pkg::NUM_W;
  localparam int SW = lprm_pkg::SMP_W;
  localparam int RW = lprm_pkg::RATE_W;
  localparam int MW = lprm_pkg::MIX_W;
  localparam int QW = lprm_pkg::QCLAMP_W;
  localparam logic signed [MW-1:0] SAT_HI = MW'((2 ** (SW - 1)) - 1);
  localparam logic signed [MW-1:0] SAT_LO = MW'(-(2 ** (SW - 1)));

  lprm_pkg::ln_state_t           st_r, st_nxt;
  logic [lprm_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic signed [SW-1:0]          cur_r, cur_nxt;
  logic signed [SW:0]            dif_r, dif_nxt;
  logic [RW-1:0]                 rsh_r, rsh_nxt;
  logic [RW-1:0]                 psh_r, psh_nxt;
  logic [RW-1:0]                 dvs_r, dvs_nxt;
  logic [lprm_pkg::GAIN_W-1:0]   gsh_r, gsh_nxt;
  logic signed [SW-1:0]          dry_r, dry_nxt;
  logic [NW-1:0]                 work_r, work_nxt;
  logic [RW-1:0]                 rem_r, rem_nxt;
  logic                          neg_r, neg_nxt;
  logic [QW-1:0]                 mq_r, mq_nxt;
  logic signed [SW-1:0]          mix_r, mix_nxt;

  logic signed [NW-1:0]          cur_ext, dif_ext;
  logic [NW-1:0]                 term_c, term_d, mul_sum, mag, qshift, prod;
  logic [RW:0]                   trial, diff;
  logic                          ge;
  logic [lprm_pkg::EXT_W-1:0]    ext_mag;
  logic [MW-1:0]                 ext_u;
  logic signed [MW-1:0]          ext_s, tot;

  always_comb begin
    cur_ext = NW'(cur_r);
    dif_ext = NW'(dif_r);
    term_c  = rsh_r[RW-1] ? cur_ext : '0;
    term_d  = psh_r[RW-1] ? dif_ext : '0;
    mul_sum = {work_r[NW-2:0], 1'b0} + term_c + term_d;
    mag     = work_r[NW-1] ? (~work_r + 1'b1) : work_r;
    trial   = {rem_r, work_r[NW-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = trial >= {1'b0, dvs_r};
    qshift  = {work_r[NW-2:0], ge};
    prod    = {work_r[NW-2:0], 1'b0} + (gsh_r[lprm_pkg::GAIN_W-1] ? NW'(mq_r) : '0);
    ext_mag = work_r[NW-1:lprm_pkg::GAIN_FRAC];
    ext_u   = {2'b00, ext_mag};
    ext_s   = neg_r ? (~ext_u + 1'b1) : ext_u;
    tot     = MW'(dry_r) + ext_s;

    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    cur_nxt  = cur_r;
    dif_nxt  = dif_r;
    rsh_nxt  = rsh_r;
    psh_nxt  = psh_r;
    dvs_nxt  = dvs_r;
    gsh_nxt  = gsh_r;
    dry_nxt  = dry_r;
    work_nxt = work_r;
    rem_nxt  = rem_r;
    neg_nxt  = neg_r;
    mq_nxt   = mq_r;
    mix_nxt  = mix_r;

    case (st_r)
      lprm_pkg::LN_IDLE: begin
        if (start) begin
          cur_nxt  = cur;
          dif_nxt  = (SW + 1)'(nxt) - (SW + 1)'(cur);
          rsh_nxt  = rate;
          psh_nxt  = phase;
          dvs_nxt  = rate;
          gsh_nxt  = gain;
          dry_nxt  = dry;
          work_nxt = '0;
          cnt_nxt  = lprm_pkg::CNT_W'(lprm_pkg::MUL_STEPS - 1);
          st_nxt   = lprm_pkg::LN_MUL;
        end
      end
      lprm_pkg::LN_MUL: begin
        // cur*rate + (nxt-cur)*phase, one bit of rate and phase per cycle
        work_nxt = mul_sum;
        rsh_nxt  = {rsh_r[RW-2:0], 1'b0};
        psh_nxt  = {psh_r[RW-2:0], 1'b0};
        if (cnt_r == '0) begin
          st_nxt = lprm_pkg::LN_ABS;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      lprm_pkg::LN_ABS: begin
        neg_nxt  = work_r[NW-1];
        work_nxt = mag;
        rem_nxt  = '0;
        cnt_nxt  = lprm_pkg::CNT_W'(lprm_pkg::DIV_STEPS - 1);
        st_nxt   = lprm_pkg::LN_DIV;
      end
      lprm_pkg::LN_DIV: begin
        work_nxt = qshift;
        rem_nxt  = ge ? diff[RW-1:0] : trial[RW-1:0];
        if (cnt_r == '0) begin
          if (|qshift[NW-1:QW]) begin
            mq_nxt = '1;
          end else begin
            mq_nxt = qshift[QW-1:0];
          end
          work_nxt = '0;
          cnt_nxt  = lprm_pkg::CNT_W'(lprm_pkg::GAIN_STEPS - 1);
          st_nxt   = lprm_pkg::LN_GAIN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      lprm_pkg::LN_GAIN: begin
        work_nxt = prod;
        gsh_nxt  = {gsh_r[lprm_pkg::GAIN_W-2:0], 1'b0};
        if (cnt_r == '0) begin
          st_nxt = lprm_pkg::LN_SAT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      lprm_pkg::LN_SAT: begin
        if (tot > SAT_HI) begin
          mix_nxt = {1'b0, {(SW - 1){1'b1}}};
        end else if (tot < SAT_LO) begin
          mix_nxt = {1'b1, {(SW - 1){1'b0}}};
        end else begin
          mix_nxt = tot[SW-1:0];
        end
        st_nxt = lprm_pkg::LN_IDLE;
      end
      default: begin
        st_nxt = lprm_pkg::LN_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= lprm_pkg::LN_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
    cur_r  <= cur_nxt;
    dif_r  <= dif_nxt;
    rsh_r  <= rsh_nxt;
    psh_r  <= psh_nxt;
    dvs_r  <= dvs_nxt;
    gsh_r  <= gsh_nxt;
    dry_r  <= dry_nxt;
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    neg_r  <= neg_nxt;
    mq_r   <= mq_nxt;
    mix_r  <= mix_nxt;
  end

  assign busy = (st_r != lprm_pkg::LN_IDLE);
  assign mix  = mix_r;

endmodule

`default_nettype wire

### rtl/looping_pcm_resampler_mixer_unit.sv
// ----------------------------------------------------------------------------
// looping_pcm_resampler_mixer_unit
// Stereo track player with linear-interpolation rate conversion and mixing.
// Start, stop, fetched-frame and tick items enter on the in_ channel; each
// gives zero to two results on the out_ channel, held in a two-entry output
// queue so the next item can be taken while results wait. One item is worked
// on at a time. A tick while playing runs a bit-serial multiply forming the
// interpolation numerator, a restoring divide by output_rate and a bit-serial
// gain multiply in each channel lane, then saturation and the push into the
// output queue. Write output_rate and gain_q8 only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module looping_pcm_resampler_mixer_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire lprm_pkg::in_item_t                   in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output lprm_pkg::out_item_t                       out_data,
  input  wire logic                                 cfg_we,
  input  wire logic [lprm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [lprm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int SW = lprm_pkg::SMP_W;
  localparam int XW = lprm_pkg::IDX_W;

  lprm_pkg::ctl_state_t               state_r, state_nxt;
  logic [lprm_pkg::RATE_W-1:0]        out_rate_r, out_rate_nxt;
  logic [lprm_pkg::GAIN_W-1:0]        gain_r, gain_nxt;
  logic [lprm_pkg::PHASE_W-1:0]       phase_acc_r, phase_acc_nxt;
  logic [XW-1:0]                      read_pos_r, read_pos_nxt;
  logic [XW-1:0]                      track_frames_r, track_frames_nxt;
  logic [XW-1:0]                      loop_pos_r, loop_pos_nxt;
  logic                               loop_on_r, loop_on_nxt;
  logic [1:0][SW-1:0]                 cur_frame_r, cur_frame_nxt;
  logic [1:0][SW-1:0]                 nxt_frame_r, nxt_frame_nxt;
  logic                               active_r, active_nxt;
  logic [lprm_pkg::ADV_W-1:0]         adv_left_r, adv_left_nxt;
  logic [1:0]                         prime_cnt_r, prime_cnt_nxt;
  lprm_pkg::out_item_t                res0_r, res0_nxt, res1_r, res1_nxt;
  logic [1:0]                         rcnt_r, rcnt_nxt;
  lprm_pkg::out_item_t                q0_r, q0_nxt, q1_r, q1_nxt;
  logic [1:0]                         qcnt_r, qcnt_nxt;

  lprm_pkg::take_t                    tk;
  logic                               calc_start, set_res;
  logic [1:0]                         lane_busy;
  logic                               pdiv_busy;
  logic signed [SW-1:0]               mix_left, mix_right;
  logic [lprm_pkg::PSUM_W-1:0]        psum, pquot;
  logic [lprm_pkg::RATE_W-1:0]        prem;
  logic [lprm_pkg::ADV_W-1:0]         adv_sat;

  assign psum    = lprm_pkg::PSUM_W'(phase_acc_r) + lprm_pkg::PSUM_W'(lprm_pkg::INPUT_RATE);
  assign adv_sat = (pquot > lprm_pkg::PSUM_W'(lprm_pkg::ADV_MAX)) ?
                   lprm_pkg::ADV_W'(lprm_pkg::ADV_MAX) : pquot[lprm_pkg::ADV_W-1:0];

  lprm_lane u_lane_left (
    .clk   (clk),
    .rst_n (rst_n),
    .start (calc_start),
    .cur   (signed'(cur_frame_r[0])),
    .nxt   (signed'(nxt_frame_r[0])),
    .phase (phase_acc_r),
    .rate  (out_rate_r),
    .gain  (gain_r),
    .dry   (in_data.dry_left),
    .busy  (lane_busy[0]),
    .mix   (mix_left)
  );

  lprm_lane u_lane_right (
    .clk   (clk),
    .rst_n (rst_n),
    .start (calc_start),
    .cur   (signed'(cur_frame_r[1])),
    .nxt   (signed'(nxt_frame_r[1])),
    .phase (phase_acc_r),
    .rate  (out_rate_r),
    .gain  (gain_r),
    .dry   (in_data.dry_right),
    .busy  (lane_busy[1]),
    .mix   (mix_right)
  );

  lprm_pdiv u_pdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (calc_start),
    .dividend (psum),
    .divisor  (out_rate_r),
    .busy     (pdiv_busy),
    .quot     (pquot),
    .rem      (prem)
  );

  always_comb begin
    tk               = lprm_pkg::take_index(read_pos_r, track_frames_r, loop_pos_r, loop_on_r);
    state_nxt        = state_r;
    out_rate_nxt     = out_rate_r;
    gain_nxt         = gain_r;
    phase_acc_nxt    = phase_acc_r;
    read_pos_nxt     = read_pos_r;
    track_frames_nxt = track_frames_r;
    loop_pos_nxt     = loop_pos_r;
    loop_on_nxt      = loop_on_r;
    cur_frame_nxt    = cur_frame_r;
    nxt_frame_nxt    = nxt_frame_r;
    active_nxt       = active_r;
    adv_left_nxt     = adv_left_r;
    prime_cnt_nxt    = prime_cnt_r;
    res0_nxt         = res0_r;
    res1_nxt         = res1_r;
    rcnt_nxt         = rcnt_r;
    q0_nxt           = q0_r;
    q1_nxt           = q1_r;
    qcnt_nxt         = qcnt_r;
    calc_start       = 1'b0;
    set_res          = 1'b0;

    if (cfg_we) begin
      case (cfg_index)
        lprm_pkg::CFG_OUTPUT_RATE: out_rate_nxt = cfg_wdata[lprm_pkg::RATE_W-1:0];
        lprm_pkg::CFG_GAIN:        gain_nxt     = cfg_wdata[lprm_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end

    // output queue: pop on transfer
    if (out_valid && !out_stall) begin
      q0_nxt   = q1_r;
      qcnt_nxt = qcnt_r - 1'b1;
    end

    case (state_r)
      lprm_pkg::CT_IDLE: begin
        if (in_valid) begin
          set_res   = 1'b1;
          res0_nxt  = '0;
          res1_nxt  = '0;
          rcnt_nxt  = 2'd0;
          state_nxt = lprm_pkg::CT_PUSH;
          case (in_data.opcode)
            lprm_pkg::OP_START: begin
              active_nxt       = 1'b0;
              track_frames_nxt = '0;
              read_pos_nxt     = '0;
              phase_acc_nxt    = '0;
              cur_frame_nxt    = '0;
              nxt_frame_nxt    = '0;
              adv_left_nxt     = '0;
              prime_cnt_nxt    = 2'd0;
              if (in_data.theme <= lprm_pkg::THEME_W'(lprm_pkg::THEME_MAX)) begin
                loop_pos_nxt = in_data.loop_start;
                if (in_data.frame_count != '0) begin
                  track_frames_nxt = in_data.frame_count;
                  loop_on_nxt      = lprm_pkg::LOOP_MASK[in_data.theme[4:0]] &&
                                     (in_data.loop_start < in_data.frame_count);
                  // read position starts at zero, so the first request is frame zero
                  prime_cnt_nxt    = 2'd2;
                  read_pos_nxt     = XW'(1);
                  res0_nxt.kind    = lprm_pkg::KIND_FETCH;
                  rcnt_nxt         = 2'd1;
                end else begin
                  loop_on_nxt = 1'b0;
                end
              end
            end
            lprm_pkg::OP_STOP: begin
              active_nxt       = 1'b0;
              track_frames_nxt = '0;
              read_pos_nxt     = '0;
              phase_acc_nxt    = '0;
              cur_frame_nxt    = '0;
              nxt_frame_nxt    = '0;
              adv_left_nxt     = '0;
              prime_cnt_nxt    = 2'd0;
            end
            lprm_pkg::OP_FETCH: begin
              if (prime_cnt_r == 2'd2) begin
                if (tk.ok) begin
                  cur_frame_nxt[0]     = in_data.src_left;
                  cur_frame_nxt[1]     = in_data.src_right;
                  prime_cnt_nxt        = 2'd1;
                  read_pos_nxt         = tk.pos;
                  res0_nxt.kind        = lprm_pkg::KIND_FETCH;
                  res0_nxt.fetch_index = tk.idx;
                  rcnt_nxt             = 2'd1;
                end else begin
                  active_nxt       = 1'b0;
                  track_frames_nxt = '0;
                  read_pos_nxt     = '0;
                  phase_acc_nxt    = '0;
                  cur_frame_nxt    = '0;
                  nxt_frame_nxt    = '0;
                  adv_left_nxt     = '0;
                  prime_cnt_nxt    = 2'd0;
                end
              end else if (prime_cnt_r == 2'd1) begin
                nxt_frame_nxt[0] = in_data.src_left;
                nxt_frame_nxt[1] = in_data.src_right;
                prime_cnt_nxt    = 2'd0;
                active_nxt       = 1'b1;
              end else if (adv_left_r != '0 && active_r) begin
                nxt_frame_nxt[0] = in_data.src_left;
                nxt_frame_nxt[1] = in_data.src_right;
                adv_left_nxt     = adv_left_r - 1'b1;
                // more advances pending: shift the frame down and request again
                if (adv_left_r != lprm_pkg::ADV_W'(1)) begin
                  cur_frame_nxt[0] = in_data.src_left;
                  cur_frame_nxt[1] = in_data.src_right;
                  if (tk.ok) begin
                    read_pos_nxt         = tk.pos;
                    res0_nxt.kind        = lprm_pkg::KIND_FETCH;
                    res0_nxt.fetch_index = tk.idx;
                    rcnt_nxt             = 2'd1;
                  end else begin
                    active_nxt   = 1'b0;
                    adv_left_nxt = '0;
                  end
                end
              end
            end
            lprm_pkg::OP_TICK: begin
              if (prime_cnt_r != 2'd0 || adv_left_r != '0) begin
                res0_nxt.kind      = lprm_pkg::KIND_REFUSE;
                res0_nxt.out_left  = in_data.dry_left;
                res0_nxt.out_right = in_data.dry_right;
                rcnt_nxt           = 2'd1;
              end else if (!active_r || out_rate_r == '0) begin
                res0_nxt.kind      = lprm_pkg::KIND_MIX;
                res0_nxt.out_left  = in_data.dry_left;
                res0_nxt.out_right = in_data.dry_right;
                rcnt_nxt           = 2'd1;
              end else begin
                calc_start = 1'b1;
                set_res    = 1'b0;
                state_nxt  = lprm_pkg::CT_CALC;
              end
            end
            default: ;
          endcase
        end
      end
      lprm_pkg::CT_CALC: begin
        if (lane_busy == 2'b00 && !pdiv_busy) begin
          set_res            = 1'b1;
          res0_nxt           = '0;
          res1_nxt           = '0;
          res0_nxt.kind      = lprm_pkg::KIND_MIX;
          res0_nxt.out_left  = mix_left;
          res0_nxt.out_right = mix_right;
          rcnt_nxt           = 2'd1;
          phase_acc_nxt      = prem;
          if (pquot != '0) begin
            adv_left_nxt  = adv_sat;
            cur_frame_nxt = nxt_frame_r;
            if (tk.ok) begin
              read_pos_nxt         = tk.pos;
              res1_nxt.kind        = lprm_pkg::KIND_FETCH;
              res1_nxt.fetch_index = tk.idx;
              rcnt_nxt             = 2'd2;
            end else begin
              active_nxt   = 1'b0;
              adv_left_nxt = '0;
            end
          end
          state_nxt = lprm_pkg::CT_PUSH;
        end
      end
      lprm_pkg::CT_PUSH: begin
        // hand over all results of the item at once into an empty queue
        if (qcnt_r == 2'd0) begin
          q0_nxt    = res0_r;
          q1_nxt    = res1_r;
          qcnt_nxt  = rcnt_r;
          state_nxt = lprm_pkg::CT_IDLE;
        end
      end
      default: begin
        state_nxt = lprm_pkg::CT_IDLE;
      end
    endcase

    if (set_res) begin
      res0_nxt.is_playing = active_nxt;
      res1_nxt.is_playing = active_nxt;
      res0_nxt.last       = (rcnt_nxt == 2'd1);
      res1_nxt.last       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= lprm_pkg::CT_IDLE;
      out_rate_r     <= lprm_pkg::OUTPUT_RATE_RST;
      gain_r         <= lprm_pkg::GAIN_RST;
      phase_acc_r    <= '0;
      read_pos_r     <= '0;
      track_frames_r <= '0;
      loop_pos_r     <= '0;
      loop_on_r      <= 1'b0;
      cur_frame_r    <= '0;
      nxt_frame_r    <= '0;
      active_r       <= 1'b0;
      adv_left_r     <= '0;
      prime_cnt_r    <= 2'd0;
      rcnt_r         <= 2'd0;
      qcnt_r         <= 2'd0;
    end else begin
      state_r        <= state_nxt;
      out_rate_r     <= out_rate_nxt;
      gain_r         <= gain_nxt;
      phase_acc_r    <= phase_acc_nxt;
      read_pos_r     <= read_pos_nxt;
      track_frames_r <= track_frames_nxt;
      loop_pos_r     <= loop_pos_nxt;
      loop_on_r      <= loop_on_nxt;
      cur_frame_r    <= cur_frame_nxt;
      nxt_frame_r    <= nxt_frame_nxt;
      active_r       <= active_nxt;
      adv_left_r     <= adv_left_nxt;
      prime_cnt_r    <= prime_cnt_nxt;
      rcnt_r         <= rcnt_nxt;
      qcnt_r         <= qcnt_nxt;
    end
    res0_r <= res0_nxt;
    res1_r <= res1_nxt;
    q0_r   <= q0_nxt;
    q1_r   <= q1_nxt;
  end

  assign in_stall  = (state_r != lprm_pkg::CT_IDLE);
  assign out_valid = (qcnt_r != 2'd0);
  assign out_data  = q0_r;

endmodule

`default_nettype wire

### rtl/lprm_chk.sv
// ----------------------------------------------------------------------------
// lprm_chk
// Port-level checks on the result channel of the resampler / mixer.
// ----------------------------------------------------------------------------
`default_nettype none

module lprm_chk (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire lprm_pkg::out_item_t  out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_fetch_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == lprm_pkg::KIND_FETCH |->
      out_data.out_left == '0 && out_data.out_right == '0)
    else $error("fetch request carries nonzero samples");

  a_index_only_on_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != lprm_pkg::KIND_FETCH |-> out_data.fetch_index == '0)
    else $error("nonzero fetch index on a sample result");

  a_two_results_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last |=> out_valid)
    else $error("result sequence ends without a last marker");

endmodule

bind looping_pcm_resampler_mixer_unit lprm_chk u_lprm_chk (.*);

`default_nettype wire

### tb/looping_pcm_resampler_mixer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// looping_pcm_resampler_mixer_unit_tb
// Drives start, stop, fetched-frame and tick transfers into the track player.
// It answers the fetch requests the block makes and predicts each result with
// its own interpolate, gain and mix arithmetic. Directed cases come first, then
// random playback under several rate and gain settings. The input channel
// idles and the output channel stalls at random.
// ----------------------------------------------------------------------------

module looping_pcm_resampler_mixer_unit_tb;
  import lprm_pkg::*;

  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 120;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SRC_RATE       = 44100;
  localparam int STEP_CAP       = 7;
  localparam int LAST_THEME     = 31;
  localparam int LOOP_THEMES    = 27;
  // one flag per theme, theme 0 in bit 0
  localparam logic [26:0] THEME_LOOPS = 27'h1F9_7BFF;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // player state as predicted
  logic [RATE_W-1:0]       rate_hz;
  logic [GAIN_W-1:0]       gain;
  int unsigned             phase;
  logic [31:0]             track_pos;
  logic [31:0]             track_len;
  logic [31:0]             loop_frame;
  bit                      loop_en;
  logic signed [SMP_W-1:0] cur_smp[2];
  logic signed [SMP_W-1:0] nxt_smp[2];
  bit                      playing;
  int unsigned             steps_owed;
  int unsigned             prime_left;

  out_item_t player_results_due[$];
  int        errors;
  int        in_calm;

  looping_pcm_resampler_mixer_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void drop_track();
    playing    = 1'b0;
    track_len  = '0;
    track_pos  = '0;
    phase      = 0;
    cur_smp[0] = '0;
    cur_smp[1] = '0;
    nxt_smp[0] = '0;
    nxt_smp[1] = '0;
    steps_owed = 0;
    prime_left = 0;
  endfunction

  // Wrap to the loop frame past the end, or report that the track is over.
  function automatic bit take_src_frame(output logic [31:0] idx);
    idx = '0;
    if (track_pos >= track_len) begin
      if (!loop_en || loop_frame >= track_len) return 1'b0;
      track_pos = loop_frame;
    end
    idx       = track_pos;
    track_pos = track_pos + 32'd1;
    return 1'b1;
  endfunction

  function automatic out_item_t fetch_request(logic [31:0] idx);
    out_item_t r;
    r             = '0;
    r.kind        = KIND_FETCH;
    r.fetch_index = idx;
    return r;
  endfunction

  function automatic logic signed [SMP_W-1:0] clamp16(longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic void play_step(in_item_t it);
    out_item_t               res[2];
    int                      n;
    int                      c;
    logic [31:0]             idx;
    longint                  rate_l;
    longint                  ph;
    longint                  interp;
    longint                  scaled;
    logic signed [SMP_W-1:0] dry[2];
    logic signed [SMP_W-1:0] mixed[2];
    int unsigned             sum;
    int unsigned             steps;
    n      = 0;
    res[0] = '0;
    res[1] = '0;
    dry[0] = it.dry_left;
    dry[1] = it.dry_right;
    case (it.opcode)
      OP_START: begin
        drop_track();
        if (it.theme <= LAST_THEME) begin
          track_len  = it.frame_count;
          loop_frame = it.loop_start;
          loop_en    = (it.theme < LOOP_THEMES) && THEME_LOOPS[it.theme[4:0]] &&
                       (it.loop_start < it.frame_count);
          if (track_len != 0 && take_src_frame(idx)) begin
            prime_left = 2;
            res[n]     = fetch_request(idx);
            n++;
          end else begin
            drop_track();
          end
        end
      end
      OP_STOP: begin
        drop_track();
      end
      OP_FETCH: begin
        if (prime_left == 2) begin
          cur_smp[0] = it.src_left;
          cur_smp[1] = it.src_right;
          if (take_src_frame(idx)) begin
            prime_left = 1;
            res[n]     = fetch_request(idx);
            n++;
          end else begin
            drop_track();
          end
        end else if (prime_left == 1) begin
          nxt_smp[0] = it.src_left;
          nxt_smp[1] = it.src_right;
          prime_left = 0;
          playing    = 1'b1;
        end else if (steps_owed > 0 && playing) begin
          nxt_smp[0] = it.src_left;
          nxt_smp[1] = it.src_right;
          steps_owed--;
          if (steps_owed > 0) begin
            cur_smp[0] = nxt_smp[0];
            cur_smp[1] = nxt_smp[1];
            if (take_src_frame(idx)) begin
              res[n] = fetch_request(idx);
              n++;
            end else begin
              playing    = 1'b0;
              steps_owed = 0;
            end
          end
        end
      end
      default: begin
        if (prime_left > 0 || steps_owed > 0) begin
          res[n].kind      = KIND_REFUSE;
          res[n].out_left  = dry[0];
          res[n].out_right = dry[1];
          n++;
        end else if (!playing || rate_hz == 0) begin
          res[n].kind      = KIND_MIX;
          res[n].out_left  = dry[0];
          res[n].out_right = dry[1];
          n++;
        end else begin
          rate_l = longint'(rate_hz);
          ph     = longint'(phase);
          for (c = 0; c < 2; c++) begin
            interp = (longint'(cur_smp[c]) * (rate_l - ph) +
                      longint'(nxt_smp[c]) * ph) / rate_l;
            scaled   = (interp * longint'(gain)) / 256;
            mixed[c] = clamp16(longint'(dry[c]) + scaled);
          end
          res[n].kind      = KIND_MIX;
          res[n].out_left  = mixed[0];
          res[n].out_right = mixed[1];
          n++;
          sum   = phase + SRC_RATE;
          steps = sum / rate_hz;
          phase = sum % rate_hz;
          if (steps > STEP_CAP) steps = STEP_CAP;
          if (steps > 0) begin
            steps_owed = steps;
            cur_smp[0] = nxt_smp[0];
            cur_smp[1] = nxt_smp[1];
            if (take_src_frame(idx)) begin
              res[n] = fetch_request(idx);
              n++;
            end else begin
              playing    = 1'b0;
              steps_owed = 0;
            end
          end
        end
      end
    endcase
    for (c = 0; c < n; c++) begin
      res[c].is_playing = playing;
      res[c].last       = (c == n - 1);
      player_results_due.push_back(res[c]);
    end
  endfunction

  task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    errors++;
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
  endtask

  // Predict on every input transfer, check every output transfer.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && in_valid && !in_stall) play_step(in_data);
    if (rst_n && out_valid && !out_stall) begin
      if (player_results_due.size() == 0) begin
        errors++;
        $display("%0t: result with none due, got kind %0d left 0x%0h right 0x%0h index 0x%0h",
                 $time, out_data.kind, out_data.out_left, out_data.out_right,
                 out_data.fetch_index);
      end else begin
        want = player_results_due.pop_front();
        if (out_data.kind !== want.kind)
          note_mismatch("kind", want.kind, out_data.kind);
        if (out_data.out_left !== want.out_left)
          note_mismatch("out_left", want.out_left, out_data.out_left);
        if (out_data.out_right !== want.out_right)
          note_mismatch("out_right", want.out_right, out_data.out_right);
        if (out_data.fetch_index !== want.fetch_index)
          note_mismatch("fetch_index", want.fetch_index, out_data.fetch_index);
        if (out_data.is_playing !== want.is_playing)
          note_mismatch("is_playing", want.is_playing, out_data.is_playing);
        if (out_data.last !== want.last)
          note_mismatch("last", want.last, out_data.last);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin : out_stall_gen
    int n;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
        out_stall = 1'b0;
      end
      // now and then a long run with no stall
      repeat (($urandom_range(0, 11) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 6))
        @(negedge clk);
    end
  end

  function automatic logic signed [SMP_W-1:0] any_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic in_item_t make_item(opcode_t op);
    in_item_t it;
    it.opcode      = op;
    it.theme       = $urandom_range(0, 65535);
    it.frame_count = $urandom;
    it.loop_start  = $urandom;
    it.src_left    = any_sample();
    it.src_right   = any_sample();
    it.dry_left    = any_sample();
    it.dry_right   = any_sample();
    return it;
  endfunction

  // Call right after a falling edge; returns at the falling edge after the transfer.
  task automatic play_item(in_item_t it);
    int gap;
    if (in_calm > 0) begin
      in_calm--;
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 49) == 0) in_calm = $urandom_range(20, 80);
    end
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  = it;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic bit fetch_outstanding();
    return prime_left > 0 || (steps_owed > 0 && playing);
  endfunction

  // Answer every fetch request until none is outstanding.
  task automatic feed_source_frames(bit extreme);
    in_item_t it;
    while (fetch_outstanding()) begin
      it = make_item(OP_FETCH);
      if (extreme) begin
        it.src_left  = 16'h7FFF;
        it.src_right = 16'h8000;
      end
      play_item(it);
    end
  endtask

  // Let all results drain and the block finish any silent work.
  task automatic settle_block();
    in_valid = 1'b0;
    while (player_results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    settle_block();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    if (idx == CFG_OUTPUT_RATE) rate_hz = data[RATE_W-1:0];
    else gain = data[GAIN_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(int unsigned rate, int unsigned gain_val);
    write_reg(CFG_OUTPUT_RATE, CFG_DATA_W'(rate));
    // upper bits beyond the gain field are don't-care
    write_reg(CFG_GAIN, {7'($urandom_range(0, 127)), GAIN_W'(gain_val)});
  endtask

  function automatic in_item_t make_stimulus(output bit counts);
    in_item_t it;
    int       r;
    bit       pending;
    pending = fetch_outstanding();
    r       = $urandom_range(0, 99);
    if (pending)
      it = make_item(r < 82 ? OP_FETCH : r < 93 ? OP_TICK : r < 96 ? OP_STOP : OP_START);
    else if (playing)
      it = make_item(r < 80 ? OP_TICK : r < 86 ? OP_FETCH : r < 90 ? OP_STOP : OP_START);
    else
      it = make_item(r < 50 ? OP_START : r < 78 ? OP_TICK : r < 90 ? OP_FETCH : OP_STOP);
    if (it.opcode == OP_START) begin
      if ($urandom_range(0, 99) < 80) it.theme = $urandom_range(0, LAST_THEME);
      r = $urandom_range(0, 99);
      if (r < 75) it.frame_count = $urandom_range(1, 40);
      else if (r < 83) it.frame_count = '0;
      r = $urandom_range(0, 99);
      if (r < 75 && it.frame_count != 0) it.loop_start = $urandom_range(0, it.frame_count - 1);
      else if (r < 80) it.loop_start = it.frame_count;
    end
    counts = (it.opcode != OP_FETCH) || pending;
    return it;
  endfunction

  task automatic test_refused_starts();
    in_item_t it;
    it             = make_item(OP_START);
    it.theme       = LAST_THEME + 1;
    it.frame_count = 10;
    play_item(it);
    it.theme = 16'hFFFF;
    play_item(it);
    it.theme       = 3;
    it.frame_count = '0;
    play_item(it);
    it           = make_item(OP_TICK);
    it.dry_left  = 16'h7FFF;
    it.dry_right = 16'h8000;
    play_item(it);
    play_item(make_item(OP_FETCH));
    play_item(make_item(OP_STOP));
  endtask

  task automatic test_short_tracks();
    in_item_t it;
    // non-looping theme: one frame dies while priming, two frames end on an advance
    it             = make_item(OP_START);
    it.theme       = 10;
    it.frame_count = 1;
    it.loop_start  = '0;
    play_item(it);
    feed_source_frames(1'b0);
    it.frame_count = 2;
    play_item(it);
    feed_source_frames(1'b0);
    repeat (3) play_item(make_item(OP_TICK));
  endtask

  task automatic test_loop_and_extrapolate();
    in_item_t it;
    it             = make_item(OP_START);
    it.theme       = 0;
    it.frame_count = 1;
    it.loop_start  = '0;
    play_item(it);
    play_item(make_item(OP_TICK));
    feed_source_frames(1'b0);
    repeat (3) play_item(make_item(OP_TICK));
    feed_source_frames(1'b0);
    // leave the phase above the new rate, then overflow the advance count
    configure(8000, 256);
    play_item(make_item(OP_TICK));
    feed_source_frames(1'b0);
    play_item(make_item(OP_TICK));
    feed_source_frames(1'b0);
  endtask

  task automatic test_saturation();
    in_item_t it;
    configure(262143, 2047);
    it             = make_item(OP_START);
    it.theme       = 19;
    it.frame_count = 4;
    it.loop_start  = 1;
    play_item(it);
    feed_source_frames(1'b1);
    it           = make_item(OP_TICK);
    it.dry_left  = 16'h7FFF;
    it.dry_right = 16'h8000;
    play_item(it);
    it.dry_left  = 16'h8000;
    it.dry_right = 16'h7FFF;
    play_item(it);
    play_item(make_item(OP_STOP));
  endtask

  task automatic test_random_playback(int items, int unsigned rate, int unsigned gain_val);
    in_item_t it;
    bit       counts;
    int       done;
    configure(rate, gain_val);
    done = 0;
    while (done < items) begin
      it = make_stimulus(counts);
      play_item(it);
      if (counts) done++;
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    errors    = 0;
    in_calm   = 0;
    rate_hz   = RATE_W'(48000);
    gain      = GAIN_W'(256);
    drop_track();
    loop_frame = '0;
    loop_en    = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    test_refused_starts();
    test_short_tracks();
    test_loop_and_extrapolate();
    test_saturation();
    test_random_playback(200, 48000, 256);
    test_random_playback(150, 8000, 1024);
    test_random_playback(150, 192000, 0);
    test_random_playback(150, 262143, 2047);
    test_random_playback(60, 0, 256);
    test_random_playback(100, 1, 700);
    test_random_playback(200, $urandom_range(8000, 192000), $urandom_range(0, 2047));

    settle_block();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/lprm_pkg.sv
rtl/lprm_pdiv.sv
rtl/lprm_lane.sv
rtl/looping_pcm_resampler_mixer_unit.sv
rtl/lprm_chk.sv
tb/looping_pcm_resampler_mixer_unit_tb.sv
